@@ sv/gbe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gbe_pkg;

    // Text store depth; must stay a power of two so the gap arithmetic wraps.
    localparam int DEPTH   = 4096;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;

    // Port field widths
    localparam int OP_W    = 3;
    localparam int CH_W    = 8;
    localparam int IDX_W   = 12;
    localparam int CUR_W   = 13;
    localparam int ST_W    = 2;

    // Request queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_LEFT   = 3'd1;
    localparam logic [OP_W-1:0] OP_RIGHT  = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

    typedef enum logic [2:0] {
        K_INSERT,
        K_LEFT,
        K_RIGHT,
        K_DELETE,
        K_READ,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CH_W-1:0]   ch;
        logic [IDX_W-1:0]  index;
    } t_cmd;

    typedef enum logic {
        S_IDLE,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

@@ sv/gbe_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gbe_front (
    input  wire logic                       i_valid,
    input  wire logic [gbe_pkg::OP_W-1:0]   i_op,
    input  wire logic [gbe_pkg::CH_W-1:0]   i_ch,
    input  wire logic [gbe_pkg::IDX_W-1:0]  i_index,
    input  wire logic                       i_q_full,
    output logic                            o_ready,
    output logic                            o_push,
    output gbe_pkg::t_cmd                   o_cmd
);
    import gbe_pkg::*;

    t_kind kind;

    // Decode the opcode; undefined codes become a no-op request.
    always_comb begin
        unique case (i_op)
            OP_INSERT: kind = K_INSERT;
            OP_LEFT:   kind = K_LEFT;
            OP_RIGHT:  kind = K_RIGHT;
            OP_DELETE: kind = K_DELETE;
            OP_READ:   kind = K_READ;
            default:   kind = K_BAD;
        endcase
    end

    assign o_ready     = !i_q_full;
    assign o_push      = i_valid && !i_q_full;
    assign o_cmd.kind  = kind;
    assign o_cmd.ch    = i_ch;
    assign o_cmd.index = i_index;

endmodule
`default_nettype wire

@@ sv/gbe_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gbe_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire gbe_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output gbe_pkg::t_cmd       o_cmd
);
    import gbe_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_cnt,  n_cnt;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = do_pop ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt + QCNT_W'(i_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

@@ sv/gbe_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gbe_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_valid,
    input  wire gbe_pkg::t_cmd              i_q_cmd,
    output logic                            o_q_pop,
    input  wire logic                       i_ready,
    output logic                            o_valid,
    output logic [gbe_pkg::CH_W-1:0]        o_read_char,
    output logic [gbe_pkg::CUR_W-1:0]       o_cursor,
    output logic [gbe_pkg::CUR_W-1:0]       o_length,
    output logic [gbe_pkg::ST_W-1:0]        o_status
);
    import gbe_pkg::*;

    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    logic [CNT_W-1:0]   r_cur, n_cur;
    logic [CNT_W-1:0]   r_len, n_len;

    logic               r_out_valid, n_out_valid;
    logic [CH_W-1:0]    r_out_char, n_out_char;
    logic [CNT_W-1:0]   r_out_cur, n_out_cur;
    logic [CNT_W-1:0]   r_out_len, n_out_len;
    logic [ST_W-1:0]    r_out_st, n_out_st;

    logic [CH_W-1:0]    r_mem [DEPTH];
    logic [CH_W-1:0]    r_rdata;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [CH_W-1:0]    mem_wdata;

    logic               out_free;
    logic               take;
    logic               two_cycle;
    logic [CNT_W-1:0]   cur_m1;
    logic [CNT_W-1:0]   gap_off;
    logic [CNT_W-1:0]   idx_ext;
    logic [CNT_W-1:0]   idx_off;

    assign out_free = !r_out_valid || i_ready;
    assign take     = (r_state == S_IDLE) && i_q_valid && out_free;
    assign cur_m1   = r_cur - 1'b1;
    // Right half starts at DEPTH - (len - cur), which wraps to cur - len.
    assign gap_off  = r_cur - r_len;
    assign idx_ext  = CNT_W'(i_q_cmd.index);
    assign idx_off  = idx_ext - r_len;

    always_comb begin
        case (i_q_cmd.kind)
            K_LEFT:  two_cycle = (r_cur != '0);
            K_RIGHT: two_cycle = (r_cur < r_len);
            K_READ:  two_cycle = (idx_ext < r_len);
            default: two_cycle = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take && two_cycle) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_kind      = r_kind;
        n_cur       = r_cur;
        n_len       = r_len;
        n_out_valid = r_out_valid && !i_ready;
        n_out_char  = r_out_char;
        n_out_cur   = r_out_cur;
        n_out_len   = r_out_len;
        n_out_st    = r_out_st;
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_cur[ADDR_W-1:0];
        mem_wdata   = i_q_cmd.ch;
        mem_re      = 1'b0;
        mem_raddr   = cur_m1[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    o_q_pop    = 1'b1;
                    n_kind     = i_q_cmd.kind;
                    n_out_char = '0;
                    n_out_st   = ST_DONE;
                    case (i_q_cmd.kind)
                        K_INSERT: begin
                            if (r_len < CNT_W'(DEPTH)) begin
                                mem_we = 1'b1;
                                n_cur  = r_cur + 1'b1;
                                n_len  = r_len + 1'b1;
                            end else begin
                                n_out_st = ST_IGNORED;
                            end
                        end
                        K_LEFT: begin
                            if (r_cur != '0) begin
                                mem_re = 1'b1;
                                n_cur  = cur_m1;
                            end else begin
                                n_out_st = ST_IGNORED;
                            end
                        end
                        K_RIGHT: begin
                            if (r_cur < r_len) begin
                                mem_re    = 1'b1;
                                mem_raddr = gap_off[ADDR_W-1:0];
                            end else begin
                                n_out_st = ST_IGNORED;
                            end
                        end
                        K_DELETE: begin
                            if (r_cur != '0) begin
                                n_cur = cur_m1;
                                n_len = r_len - 1'b1;
                            end else begin
                                n_out_st = ST_IGNORED;
                            end
                        end
                        K_READ: begin
                            if (idx_ext < r_len) begin
                                mem_re    = 1'b1;
                                mem_raddr = (idx_ext < r_cur) ? i_q_cmd.index[ADDR_W-1:0]
                                                              : idx_off[ADDR_W-1:0];
                            end else begin
                                n_out_st = ST_RANGE;
                            end
                        end
                        default: n_out_st = ST_IGNORED;
                    endcase
                    // Requests without a RAM read post their result now.
                    if (!two_cycle) begin
                        n_out_valid = 1'b1;
                        n_out_cur   = n_cur;
                        n_out_len   = n_len;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = '0;
                    n_out_st    = ST_DONE;
                    mem_wdata   = r_rdata;
                    case (r_kind)
                        K_LEFT: begin
                            mem_we    = 1'b1;
                            mem_waddr = gap_off[ADDR_W-1:0];
                        end
                        K_RIGHT: begin
                            mem_we = 1'b1;
                            n_cur  = r_cur + 1'b1;
                        end
                        default: n_out_char = r_rdata;
                    endcase
                    n_out_cur = n_cur;
                    n_out_len = r_len;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_out_char <= n_out_char;
        r_out_cur  <= n_out_cur;
        r_out_len  <= n_out_len;
        r_out_st   <= n_out_st;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_char = r_out_char;
    assign o_cursor    = CUR_W'(r_out_cur);
    assign o_length    = CUR_W'(r_out_len);
    assign o_status    = r_out_st;

endmodule
`default_nettype wire

@@ sv/gap_buffer_line_editor_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Single-line text buffer with a cursor, kept as a gap buffer in one RAM.
// Input channel (i_valid / o_ready): one request per accepted item, carrying
// i_op (insert, left, right, delete, read), i_ch for inserts, i_index for reads.
// Output channel (o_valid / i_ready): exactly one result per request, in order:
// o_read_char, o_cursor, o_length, o_status.
// Requests are decoded into a two-entry queue; the execution side pops them.
// Insert, delete, boundary no-ops and bad opcodes finish in the execute step;
// cursor moves and in-range reads first need one registered RAM read before
// the write across the gap or the result.
// Moves and reads hold the execution side until their result is posted, so it
// takes no new request meanwhile; short requests can follow back to back.
// Reset clears cursor, length, queue and the result valid flag; the text RAM is
// not cleared, and no entry is read before it is written.
// When the receiver stalls, the result is held in the output register, the
// execution side stops popping, and the queue fills before o_ready drops.
module gap_buffer_line_editor_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [gbe_pkg::OP_W-1:0]   i_op,
    input  wire logic [gbe_pkg::CH_W-1:0]   i_ch,
    input  wire logic [gbe_pkg::IDX_W-1:0]  i_index,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [gbe_pkg::CH_W-1:0]        o_read_char,
    output logic [gbe_pkg::CUR_W-1:0]       o_cursor,
    output logic [gbe_pkg::CUR_W-1:0]       o_length,
    output logic [gbe_pkg::ST_W-1:0]        o_status
);
    import gbe_pkg::*;

    // Request path: decode -> queue -> execute
    logic  q_full;
    logic  q_push;
    t_cmd  push_cmd;
    logic  q_valid;
    t_cmd  q_cmd;
    logic  q_pop;

    // Classify the opcode and accept while the queue has room.
    gbe_front u_front (
        .i_valid  (i_valid),
        .i_op     (i_op),
        .i_ch     (i_ch),
        .i_index  (i_index),
        .i_q_full (q_full),
        .o_ready  (o_ready),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    // Decouple acceptance from execution so either side can stall.
    gbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Hold cursor, length and text RAM; post one result per request.
    gbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_read_char (o_read_char),
        .o_cursor    (o_cursor),
        .o_length    (o_length),
        .o_status    (o_status)
    );

endmodule
`default_nettype wire

@@ dv/gap_buffer_line_editor_core_test.sv @@
`timescale 1ns / 1ps
module gap_buffer_line_editor_core_test;
    import gbe_pkg::*;

    typedef struct {
        logic [CH_W-1:0]  read_char;
        logic [CUR_W-1:0] cursor;
        logic [CUR_W-1:0] length;
        logic [ST_W-1:0]  status;
    } t_edit_result;

    // Receiver behavior; each mode holds for a random stretch of cycles.
    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_MOSTLY,
        RDY_LONG_STALL
    } t_ready_mode;

    // Tracks the line as a gap buffer and queues one expected result per request.
    class line_edit_scoreboard;
        logic [CH_W-1:0] text_mem [DEPTH];
        int              cursor_at;
        int              text_count;
        int              errors;
        t_edit_result    expected_results [$];

        function new();
            cursor_at  = 0;
            text_count = 0;
            errors     = 0;
        endfunction

        function int pending_count();
            return expected_results.size();
        endfunction

        // Apply one accepted request to the line and queue its result.
        function void note_request(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                   logic [IDX_W-1:0] idx);
            t_edit_result res;
            res.read_char = '0;
            res.status    = ST_DONE;
            case (op)
                OP_INSERT: begin
                    if (text_count >= DEPTH) begin
                        res.status = ST_IGNORED;
                    end else begin
                        text_mem[cursor_at] = ch;
                        cursor_at++;
                        text_count++;
                    end
                end
                OP_LEFT: begin
                    if (cursor_at == 0) begin
                        res.status = ST_IGNORED;
                    end else begin
                        // carry the character left of the cursor to the top part
                        cursor_at--;
                        text_mem[DEPTH - (text_count - cursor_at)] = text_mem[cursor_at];
                    end
                end
                OP_RIGHT: begin
                    if (cursor_at >= text_count) begin
                        res.status = ST_IGNORED;
                    end else begin
                        text_mem[cursor_at] = text_mem[DEPTH - (text_count - cursor_at)];
                        cursor_at++;
                    end
                end
                OP_DELETE: begin
                    if (cursor_at == 0) begin
                        res.status = ST_IGNORED;
                    end else begin
                        cursor_at--;
                        text_count--;
                    end
                end
                OP_READ: begin
                    if (idx >= text_count) begin
                        res.status = ST_RANGE;
                    end else if (idx < cursor_at) begin
                        res.read_char = text_mem[idx];
                    end else begin
                        res.read_char = text_mem[(DEPTH - text_count + idx) % DEPTH];
                    end
                end
                default: begin
                    res.status = ST_IGNORED;
                end
            endcase
            res.cursor = CUR_W'(cursor_at);
            res.length = CUR_W'(text_count);
            expected_results.push_back(res);
        endfunction

        function void report_field(string name, logic [CUR_W-1:0] exp_val,
                                   logic [CUR_W-1:0] act_val);
            if (act_val !== exp_val) begin
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        // Compare one accepted result against the oldest expectation.
        function void check_result(logic [CH_W-1:0] read_char, logic [CUR_W-1:0] cursor,
                                   logic [CUR_W-1:0] length, logic [ST_W-1:0] status);
            t_edit_result exp_res;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual char %0d cursor %0d",
                         $time, read_char, cursor);
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            report_field("read_char", CUR_W'(exp_res.read_char), CUR_W'(read_char));
            report_field("cursor", exp_res.cursor, cursor);
            report_field("length", exp_res.length, length);
            report_field("status", CUR_W'(exp_res.status), CUR_W'(status));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n  = 1'b0;
    logic              i_valid  = 1'b0;
    logic              o_ready;
    logic [OP_W-1:0]   i_op     = '0;
    logic [CH_W-1:0]   i_ch     = '0;
    logic [IDX_W-1:0]  i_index  = '0;
    logic              o_valid;
    logic              i_ready  = 1'b0;
    logic [CH_W-1:0]   o_read_char;
    logic [CUR_W-1:0]  o_cursor;
    logic [CUR_W-1:0]  o_length;
    logic [ST_W-1:0]   o_status;

    line_edit_scoreboard sb = new();
    int                  burst_left = 0;
    t_ready_mode         ready_mode = RDY_ALWAYS;
    int                  mode_left  = 0;

    gap_buffer_line_editor_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_ch        (i_ch),
        .i_index     (i_index),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_read_char (o_read_char),
        .o_cursor    (o_cursor),
        .o_length    (o_length),
        .o_status    (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("gap_buffer_line_editor_core_test NOT OK");
        $finish;
    end

    // Receiver stall pattern, independent of the sender.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(10, 80);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            RDY_ALWAYS:     i_ready <= 1'b1;
            RDY_COIN:       i_ready <= 1'($urandom_range(0, 1));
            RDY_MOSTLY:     i_ready <= ($urandom_range(0, 7) != 0);
            RDY_LONG_STALL: i_ready <= ((mode_left % 16) < 3);
            default:        i_ready <= 1'b1;
        endcase
    end

    // Outputs settle after the rising edge, so the negedge shows what the next edge accepts.
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_read_char, o_cursor, o_length, o_status);
        end
    end

    // Drive one request and hold it until accepted; returns at the accepting edge.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                                input logic [IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_op    <= op;
        i_ch    <= ch;
        i_index <= idx;
        do begin
            @(negedge i_clk);
        end while (!o_ready);
        sb.note_request(op, ch, idx);
        @(posedge i_clk);
    endtask

    // Hold off the sender until every outstanding request has its result.
    task automatic drain_results();
        i_valid    <= 1'b0;
        burst_left = 0;
        do begin
            @(posedge i_clk);
        end while (sb.pending_count() != 0);
    endtask

    task automatic send_random_edit(input int insert_weight);
        int              pick;
        logic [OP_W-1:0] op;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < insert_weight) begin
            op = OP_INSERT;
        end else if (pick < insert_weight + (96 - insert_weight) * 2 / 9) begin
            op = OP_LEFT;
        end else if (pick < insert_weight + (96 - insert_weight) * 4 / 9) begin
            op = OP_RIGHT;
        end else if (pick < insert_weight + (96 - insert_weight) * 5 / 9) begin
            op = OP_DELETE;
        end else if (pick < 96) begin
            op = OP_READ;
        end else begin
            op = OP_W'($urandom_range(OP_READ + 1, (1 << OP_W) - 1));
        end
        // mostly in-range reads, the rest anywhere in the index field
        if (sb.text_count > 0 && $urandom_range(0, 4) != 0) begin
            idx = IDX_W'($urandom_range(0, sb.text_count - 1));
        end else begin
            idx = IDX_W'($urandom());
        end
        send_request(op, CH_W'($urandom()), idx);
    endtask

    initial begin
        int k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty line: every boundary case and each unknown opcode; then inserts, reads, moves and deletes.
        send_request(OP_READ, '0, '0);
        send_request(OP_LEFT, '0, '0);
        send_request(OP_RIGHT, '1, '1);
        send_request(OP_DELETE, '0, '0);
        for (k = OP_READ + 1; k < (1 << OP_W); k++) begin
            send_request(OP_W'(k), '1, '1);
        end
        send_request(OP_INSERT, '0, '0);
        send_request(OP_INSERT, '1, '1);
        send_request(OP_INSERT, 8'hA5, '0);
        send_request(OP_READ, '0, '0);
        send_request(OP_READ, '0, 12'd1);
        send_request(OP_READ, '0, '1);
        send_request(OP_LEFT, '0, '0);
        send_request(OP_READ, '0, 12'd2);
        send_request(OP_RIGHT, '0, '0);
        send_request(OP_RIGHT, '0, '0);
        send_request(OP_LEFT, '0, '0);
        send_request(OP_LEFT, '0, '0);
        send_request(OP_DELETE, '0, '0);
        send_request(OP_DELETE, '0, '0);
        send_request(OP_READ, '0, '0);
        send_request(OP_READ, '0, 12'd1);
        drain_results();

        repeat (1030) send_random_edit(36);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("gap_buffer_line_editor_core_test OK");
        end else begin
            $display("gap_buffer_line_editor_core_test NOT OK");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
sv/gbe_pkg.sv
sv/gbe_front.sv
sv/gbe_queue.sv
sv/gbe_back.sv
sv/gap_buffer_line_editor_core.sv
dv/gap_buffer_line_editor_core_test.sv
